// ===== sv/kcq_pkg.sv =====
// ----------------------------------------------------------------------------
// kcq_pkg: shared types and constants of the k-means colour quantiser
// Command codes, payload structs, configuration and sequencer state.
// ----------------------------------------------------------------------------
package kcq_pkg;

  localparam int unsigned MAX_PIXELS_DEF   = 65536;
  localparam int unsigned MAX_CLUSTERS_DEF = 16;
  localparam int unsigned CHANNELS         = 3;
  localparam int unsigned CH_W             = 8;
  localparam int unsigned FIX_W            = 16;
  localparam int unsigned C_W              = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned DIST_W           = 2 * FIX_W + 2;
  localparam int unsigned CFG_W            = 17;
  localparam int unsigned CFG_IDX_W        = 2;

  localparam logic [4:0]  CLUSTERS_RST = 5'd5;
  localparam logic [7:0]  MAX_ITER_RST = 8'd100;
  localparam logic [16:0] PIXELS_RST   = 17'd65536;

  typedef enum logic [2:0] {
    CMD_LOAD   = 3'd0,
    CMD_SEED   = 3'd1,
    CMD_RUN    = 3'd2,
    CMD_RD_PIX = 3'd3,
    CMD_RD_CEN = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLUSTERS = 2'd0,
    CFG_MAX_ITER = 2'd1,
    CFG_PIXELS   = 2'd2
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SEED_RD,
    ST_SEED_WR,
    ST_RP_RD,
    ST_RP_WT,
    ST_CLR,
    ST_P_RD,
    ST_DIST,
    ST_DRAIN,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_U_RD,
    ST_U_CHK,
    ST_U_DIV,
    ST_U_WAIT,
    ST_PASS,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] index;
    logic [3:0]  center_select;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } in_item_t;

  typedef struct packed {
    logic [3:0] cluster;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [8:0] passes_used;
    logic       converged;
  } out_item_t;

  typedef struct packed {
    logic [4:0]  cluster_count;
    logic [7:0]  max_iterations;
    logic [16:0] pixel_count;
  } cfg_t;

  typedef struct packed {
    logic     avail;
    in_item_t item;
  } fq_head_t;

endpackage

// ===== sv/kcq_front.sv =====
// ----------------------------------------------------------------------------
// kcq_front: command intake
// Accepts input transfers, drops unknown commands and queues the rest in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module kcq_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  kcq_pkg::in_item_t in_item_i,
  input  logic              pop_i,
  output kcq_pkg::fq_head_t head_o
);
  import kcq_pkg::*;

  in_item_t   mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       known, push, pop;

  // classify: only defined command codes enter the queue
  always_comb begin
    case (cmd_e'(in_item_i.command))
      CMD_LOAD, CMD_SEED, CMD_RUN, CMD_RD_PIX, CMD_RD_CEN: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o && known;
  assign pop        = pop_i && (cnt_q != 2'd0);

  assign head_o.avail = (cnt_q != 2'd0);
  assign head_o.item  = mem_q[rd_q];

  // hold queue payload
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_item_i;
  end

  // advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== sv/kcq_div.sv =====
// ----------------------------------------------------------------------------
// kcq_div: restoring divider
// Unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kcq_div #(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;

  // one trial subtraction
  assign rem_sh = {rem_q, quo_q[NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};

  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      if (!diff[DEN_W+1]) begin
        rem_q <= diff[DEN_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DEN_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== sv/kcq_back.sv =====
// ----------------------------------------------------------------------------
// kcq_back: clustering engine
// Pixel and assignment memories, centre file, accumulators and the pass
// sequencer; drives the output register.
// ----------------------------------------------------------------------------
module kcq_back #(
  parameter int unsigned MAX_PIXELS   = kcq_pkg::MAX_PIXELS_DEF,
  parameter int unsigned MAX_CLUSTERS = kcq_pkg::MAX_CLUSTERS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kcq_pkg::cfg_t      cfg_i,
  input  kcq_pkg::fq_head_t  head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output kcq_pkg::out_item_t out_item_o
);
  import kcq_pkg::*;

  localparam int unsigned PIX_AW = $clog2(MAX_PIXELS);
  localparam int unsigned CL_W   = $clog2(MAX_CLUSTERS);
  localparam int unsigned K_W    = CL_W + 1;
  localparam int unsigned CNT_W  = PIX_AW + 1;
  localparam int unsigned SUM_W  = CH_W + PIX_AW;
  localparam int unsigned DIV_W  = SUM_W + CH_W;
  localparam int unsigned ROW_W  = CNT_W + CHANNELS * SUM_W;
  localparam int unsigned PIX_W  = CHANNELS * CH_W;

  typedef logic [CHANNELS-1:0][FIX_W-1:0] center_t;

  state_e state_q, state_d;
  in_item_t cur_q;
  out_item_t res_q, out_q;
  logic out_valid_q;

  // memories
  logic [PIX_W-1:0] pix_mem [MAX_PIXELS];
  logic [CL_W-1:0]  asg_mem [MAX_PIXELS];
  logic [ROW_W-1:0] acc_mem [MAX_CLUSTERS];
  logic [PIX_W-1:0] pix_rd_q;
  logic [CL_W-1:0]  asg_rd_q;
  logic [ROW_W-1:0] acc_rd_q;

  center_t cen_q [MAX_CLUSTERS];
  center_t cen_rd;

  logic [K_W-1:0]     j_q, k_eff;
  logic [C_W-1:0]     c_q;
  logic [PIX_AW-1:0]  p_q;
  logic [CNT_W-1:0]   n_eff;
  logic [8:0]         pc_q, pc_inc;
  logic               same_q;
  logic [DIST_W-1:0]  bd_q, dsum;
  logic [CL_W-1:0]    best_q, sqj_q;
  logic               sqv_q;
  logic [2*FIX_W-1:0] sq_q [CHANNELS];

  // control strobes
  logic              pix_re, acc_re, acc_we, asg_re, div_start, emit_take;
  logic [PIX_AW-1:0] pix_raddr;
  logic [CL_W-1:0]   acc_addr, cen_ra;
  logic [ROW_W-1:0]  acc_wdata;
  logic              div_done;
  logic [DIV_W-1:0]  div_quo, div_num;

  logic              head_idx_ok, cur_idx_ok, head_sel_ok, cur_sel_ok;
  logic [PIX_AW-1:0] head_addr, cur_addr;
  logic              j_last, p_last, cnt_zero, load_we;

  // effective cluster and pixel counts
  always_comb begin
    if (cfg_i.cluster_count == 5'd0) k_eff = K_W'(1);
    else if (32'(cfg_i.cluster_count) > MAX_CLUSTERS) k_eff = K_W'(MAX_CLUSTERS);
    else k_eff = K_W'(cfg_i.cluster_count);
    if (cfg_i.pixel_count == 17'd0) n_eff = CNT_W'(1);
    else if (32'(cfg_i.pixel_count) > MAX_PIXELS) n_eff = CNT_W'(MAX_PIXELS);
    else n_eff = CNT_W'(cfg_i.pixel_count);
  end

  assign head_idx_ok = 32'(head_i.item.index) < MAX_PIXELS;
  assign cur_idx_ok  = 32'(cur_q.index) < MAX_PIXELS;
  assign head_sel_ok = 32'(head_i.item.center_select) < MAX_CLUSTERS;
  assign cur_sel_ok  = 32'(cur_q.center_select) < MAX_CLUSTERS;
  assign head_addr   = PIX_AW'(head_i.item.index);
  assign cur_addr    = PIX_AW'(cur_q.index);

  assign j_last   = (j_q == k_eff - K_W'(1));
  assign p_last   = (CNT_W'(p_q) == n_eff - CNT_W'(1));
  assign cnt_zero = (acc_rd_q[ROW_W-1 -: CNT_W] == '0);
  assign pc_inc   = pc_q + 9'd1;
  assign pop_o    = (state_q == ST_IDLE) && head_i.avail;
  assign load_we  = pop_o && (cmd_e'(head_i.item.command) == CMD_LOAD) && head_idx_ok;
  assign emit_take = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          case (cmd_e'(head_i.item.command))
            CMD_SEED:   state_d = ST_SEED_RD;
            CMD_RUN:    state_d = ST_CLR;
            CMD_RD_PIX: state_d = ST_RP_RD;
            CMD_RD_CEN: state_d = ST_EMIT;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_SEED_RD: state_d = ST_SEED_WR;
      ST_SEED_WR: state_d = ST_IDLE;
      ST_RP_RD:   state_d = cur_idx_ok ? ST_RP_WT : ST_EMIT;
      ST_RP_WT:   state_d = ST_EMIT;
      ST_CLR:     state_d = j_last ? ST_P_RD : ST_CLR;
      ST_P_RD:    state_d = ST_DIST;
      ST_DIST:    state_d = j_last ? ST_DRAIN : ST_DIST;
      ST_DRAIN:   state_d = ST_ACC_RD;
      ST_ACC_RD:  state_d = ST_ACC_WR;
      ST_ACC_WR:  state_d = p_last ? ST_U_RD : ST_P_RD;
      ST_U_RD:    state_d = (j_q == k_eff) ? ST_PASS : ST_U_CHK;
      ST_U_CHK:   state_d = cnt_zero ? ST_U_RD : ST_U_DIV;
      ST_U_DIV:   state_d = ST_U_WAIT;
      ST_U_WAIT: begin
        if (div_done) state_d = (c_q == C_W'(CHANNELS - 1)) ? ST_U_RD : ST_U_DIV;
      end
      ST_PASS: begin
        if (same_q || (pc_inc > {1'b0, cfg_i.max_iterations})) state_d = ST_EMIT;
        else state_d = ST_CLR;
      end
      ST_EMIT:    state_d = emit_take ? ST_IDLE : ST_EMIT;
      default:    state_d = ST_IDLE;
    endcase
  end

  // memory and unit strobes
  always_comb begin
    pix_re    = 1'b0;
    pix_raddr = p_q;
    asg_re    = 1'b0;
    acc_re    = 1'b0;
    acc_we    = 1'b0;
    acc_addr  = j_q[CL_W-1:0];
    acc_wdata = '0;
    div_start = 1'b0;
    cen_ra    = j_q[CL_W-1:0];
    case (state_q)
      ST_IDLE:    cen_ra = CL_W'(head_i.item.center_select);
      ST_SEED_RD: begin
        pix_re    = 1'b1;
        pix_raddr = cur_addr;
      end
      ST_RP_RD:   asg_re = 1'b1;
      ST_RP_WT:   cen_ra = asg_rd_q;
      ST_CLR:     acc_we = 1'b1;
      ST_P_RD:    pix_re = 1'b1;
      ST_ACC_RD: begin
        acc_re   = 1'b1;
        acc_addr = best_q;
      end
      ST_ACC_WR: begin
        acc_we   = 1'b1;
        acc_addr = best_q;
        acc_wdata[ROW_W-1 -: CNT_W] = acc_rd_q[ROW_W-1 -: CNT_W] + CNT_W'(1);
        for (int c = 0; c < CHANNELS; c++) begin
          acc_wdata[c*SUM_W +: SUM_W] = acc_rd_q[c*SUM_W +: SUM_W]
                                        + SUM_W'(pix_rd_q[c*CH_W +: CH_W]);
        end
      end
      ST_U_RD:    acc_re = (j_q != k_eff);
      ST_U_DIV:   div_start = 1'b1;
      default:    ;
    endcase
  end

  assign cen_rd  = cen_q[cen_ra];
  assign div_num = {acc_rd_q[c_q*SUM_W +: SUM_W], {CH_W{1'b0}}};

  kcq_div #(
    .NUM_W (DIV_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (acc_rd_q[ROW_W-1 -: CNT_W]),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // pixel memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (load_we) pix_mem[head_addr] <= {head_i.item.red, head_i.item.green, head_i.item.blue};
    if (pix_re)  pix_rd_q <= pix_mem[pix_raddr];
  end

  // assignment memory
  always_ff @(posedge clk_i) begin
    if (state_q == ST_ACC_WR) asg_mem[p_q] <= best_q;
    if (asg_re) asg_rd_q <= asg_mem[cur_addr];
  end

  // accumulator memory: member count over channel sums
  always_ff @(posedge clk_i) begin
    if (acc_we) acc_mem[acc_addr] <= acc_wdata;
    if (acc_re) acc_rd_q <= acc_mem[acc_addr];
  end

  // distance: squares, then sum
  always_ff @(posedge clk_i) begin
    logic [FIX_W-1:0] a, b, e;
    for (int c = 0; c < CHANNELS; c++) begin
      a = {pix_rd_q[c*CH_W +: CH_W], {CH_W{1'b0}}};
      b = cen_rd[c];
      e = (a > b) ? a - b : b - a;
      sq_q[c] <= e * e;
    end
    sqj_q <= j_q[CL_W-1:0];
  end

  always_comb begin
    dsum = '0;
    for (int c = 0; c < CHANNELS; c++) dsum = dsum + DIST_W'(sq_q[c]);
  end

  // centre file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_CLUSTERS; k++) cen_q[k] <= '0;
    end else if ((state_q == ST_SEED_WR) && cur_idx_ok && cur_sel_ok) begin
      for (int c = 0; c < CHANNELS; c++) begin
        cen_q[CL_W'(cur_q.center_select)][c] <= {pix_rd_q[c*CH_W +: CH_W], {CH_W{1'b0}}};
      end
    end else if ((state_q == ST_U_WAIT) && div_done) begin
      cen_q[j_q[CL_W-1:0]][c_q] <= div_quo[FIX_W-1:0];
    end
  end

  // sequencer counters and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      sqv_q       <= 1'b0;
      j_q         <= '0;
      c_q         <= '0;
      p_q         <= '0;
      pc_q        <= '0;
      same_q      <= 1'b1;
    end else begin
      state_q <= state_d;
      sqv_q   <= (state_q == ST_DIST);
      if (out_valid_q && !out_stall_i && (state_q != ST_EMIT)) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          j_q    <= '0;
          pc_q   <= '0;
          same_q <= 1'b1;
        end
        ST_CLR: begin
          j_q <= j_last ? '0 : j_q + K_W'(1);
          p_q <= '0;
        end
        ST_DIST:  j_q <= j_last ? '0 : j_q + K_W'(1);
        ST_ACC_WR: begin
          p_q <= p_q + PIX_AW'(1);
          j_q <= '0;
        end
        ST_U_CHK: begin
          c_q <= '0;
          if (cnt_zero) j_q <= j_q + K_W'(1);
        end
        ST_U_WAIT: begin
          if (div_done) begin
            if (div_quo[FIX_W-1:0] != cen_rd[c_q]) same_q <= 1'b0;
            if (c_q == C_W'(CHANNELS - 1)) j_q <= j_q + K_W'(1);
            else c_q <= c_q + C_W'(1);
          end
        end
        ST_PASS: begin
          pc_q <= pc_inc;
          j_q  <= '0;
          if (!(same_q || (pc_inc > {1'b0, cfg_i.max_iterations}))) same_q <= 1'b1;
        end
        ST_EMIT: begin
          if (emit_take) out_valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // best-centre search, result build and output register
  always_ff @(posedge clk_i) begin
    if (sqv_q && ((sqj_q == '0) || (dsum < bd_q))) begin
      bd_q   <= dsum;
      best_q <= sqj_q;
    end
    if (pop_o) cur_q <= head_i.item;
    case (state_q)
      ST_IDLE: begin
        res_q <= '{cluster:     head_i.item.center_select,
                   out_blue:    head_sel_ok ? cen_rd[0][FIX_W-1 -: CH_W] : '0,
                   out_green:   head_sel_ok ? cen_rd[1][FIX_W-1 -: CH_W] : '0,
                   out_red:     head_sel_ok ? cen_rd[2][FIX_W-1 -: CH_W] : '0,
                   passes_used: '0,
                   converged:   1'b0};
      end
      ST_RP_RD: res_q <= '0;
      ST_RP_WT: begin
        res_q.cluster   <= 4'(32'(asg_rd_q));
        res_q.out_blue  <= cen_rd[0][FIX_W-1 -: CH_W];
        res_q.out_green <= cen_rd[1][FIX_W-1 -: CH_W];
        res_q.out_red   <= cen_rd[2][FIX_W-1 -: CH_W];
      end
      ST_PASS: begin
        res_q <= '{cluster:     '0,
                   out_blue:    '0,
                   out_green:   '0,
                   out_red:     '0,
                   passes_used: pc_inc,
                   converged:   same_q};
      end
      ST_EMIT: if (emit_take) out_q <= res_q;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== sv/kmeans_color_quantizer_top.sv =====
// ----------------------------------------------------------------------------
// kmeans_color_quantizer_top: k-means RGB colour quantiser
// Usage: a plain configuration write port sets cluster count, pass limit and
// pixel count; the user must write these only while the block is idle (unchecked).
// The input channel (in_valid_i / in_stall_o) carries commands: load pixel,
// seed centre, run, read pixel, read centre. A transfer takes place when valid
// is high and stall is low. Commands enter a two-entry queue and are carried
// out one at a time by the engine.
// A run pass is paced by the one-centre-per-cycle distance unit and the
// bit-serial divider (DIV_W = 32 with 65536 pixels); an empty cluster skips
// its divides. At most max_iterations + 1 passes run.
// Results leave through an output register (out_valid_o / out_stall_i); while
// the receiver stalls the result holds and the next result waits in the
// engine. Reset clears the queue, the centres, the output and configuration
// to 5 clusters, 100 iterations and 65536 pixels; pixel memories are not cleared.
// ----------------------------------------------------------------------------
module kmeans_color_quantizer_top #(
  parameter int unsigned MAX_PIXELS   = kcq_pkg::MAX_PIXELS_DEF,
  parameter int unsigned MAX_CLUSTERS = kcq_pkg::MAX_CLUSTERS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kcq_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [kcq_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  kcq_pkg::in_item_t               in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output kcq_pkg::out_item_t              out_item_o
);
  import kcq_pkg::*;

  cfg_t     cfg_q;
  fq_head_t head;
  logic     pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cluster_count  <= CLUSTERS_RST;
      cfg_q.max_iterations <= MAX_ITER_RST;
      cfg_q.pixel_count    <= PIXELS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CLUSTERS: cfg_q.cluster_count  <= cfg_data_i[4:0];
        CFG_MAX_ITER: cfg_q.max_iterations <= cfg_data_i[7:0];
        CFG_PIXELS:   cfg_q.pixel_count    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  kcq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .pop_i      (pop),
    .head_o     (head)
  );

  kcq_back #(
    .MAX_PIXELS   (MAX_PIXELS),
    .MAX_CLUSTERS (MAX_CLUSTERS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
